@@ rtl/xtea_pkg.sv @@
// ----------------------------------------------------------------------------
// xtea_pkg
// shared types, constants and the round mixing function of the xtea cipher
// ----------------------------------------------------------------------------
package xtea_pkg;

	// golden-ratio round constant
	localparam logic [31:0] DELTA = 32'h9E37_79B9;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_ROUND_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3  = 3'd4;

	// round_count register width and reset
	localparam int unsigned ROUND_COUNT_W   = 7;
	localparam int unsigned ROUND_COUNT_RST = 32;

	// opcodes
	localparam logic OP_ENCRYPT = 1'b0;
	localparam logic OP_DECRYPT = 1'b1;

	typedef logic [3:0][31:0] key_t;

	// one block in flight
	typedef struct packed {
		logic        op;
		logic [31:0] v0;
		logic [31:0] v1;
		logic [31:0] sum;
	} stage_t;

	function automatic logic [31:0] mix(input logic [31:0] x, input logic [31:0] sum,
		input logic [31:0] key_word);
		logic [31:0] f;
		f = ((x << 4) ^ (x >> 5)) + x;
		return f ^ (sum + key_word);
	endfunction

endpackage

@@ rtl/xtea_ifs.sv @@
// ----------------------------------------------------------------------------
// xtea channel interfaces
// block input, block output and configuration write channels
// ----------------------------------------------------------------------------
interface xtea_in_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [31:0] in_word_low;
	logic [31:0] in_word_high;

	modport source (output valid, opcode, in_word_low, in_word_high, input ready);
	modport sink   (input valid, opcode, in_word_low, in_word_high, output ready);
endinterface

interface xtea_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_word_low;
	logic [31:0] out_word_high;

	modport source (output valid, out_word_low, out_word_high, input ready);
	modport sink   (input valid, out_word_low, out_word_high, output ready);
endinterface

interface xtea_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/xtea_half_round.sv @@
// ----------------------------------------------------------------------------
// xtea_half_round
// one registered feistel half-round, used in both cipher directions
// ----------------------------------------------------------------------------
module xtea_half_round #(
	parameter bit SECOND_HALF = 1'b0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            active,
	input  xtea_pkg::key_t  key,
	input  logic            in_valid,
	input  xtea_pkg::stage_t in_stage,
	output logic            out_valid_s1,
	output xtea_pkg::stage_t out_stage_s1
);
	import xtea_pkg::*;

	logic        upd_v0;
	logic        key_hi;
	logic [1:0]  key_sel;
	logic [31:0] x;
	logic [31:0] m;
	stage_t      nxt;

	// encrypt: first half feeds v0, second feeds v1; decrypt runs the mirror image
	assign upd_v0  = SECOND_HALF ? (in_stage.op == OP_DECRYPT) : (in_stage.op == OP_ENCRYPT);
	assign key_hi  = SECOND_HALF ? (in_stage.op == OP_ENCRYPT) : (in_stage.op == OP_DECRYPT);
	assign key_sel = key_hi ? in_stage.sum[12:11] : in_stage.sum[1:0];
	assign x       = upd_v0 ? in_stage.v1 : in_stage.v0;
	assign m       = mix(x, in_stage.sum, key[key_sel]);

	always_comb begin
		nxt = in_stage;
		if (active) begin
			if (in_stage.op == OP_ENCRYPT) begin
				if (upd_v0) nxt.v0 = in_stage.v0 + m;
				else        nxt.v1 = in_stage.v1 + m;
			end else begin
				if (upd_v0) nxt.v0 = in_stage.v0 - m;
				else        nxt.v1 = in_stage.v1 - m;
			end
			if (!SECOND_HALF) begin
				nxt.sum = (in_stage.op == OP_ENCRYPT) ? in_stage.sum + DELTA
					: in_stage.sum - DELTA;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s1 <= 1'b0;
		end else if (en) begin
			out_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_stage_s1 <= nxt;
		end
	end

endmodule

@@ rtl/xtea_block_cipher.sv @@
// ----------------------------------------------------------------------------
// xtea_block_cipher
// pipelined xtea encrypt / decrypt of 64-bit blocks under a 128-bit key
// ----------------------------------------------------------------------------
//
//  channel   dir   payload                                   transfer when
//  -------   ---   ---------------------------------------   ---------------
//  blk_in    in    opcode, in_word_low, in_word_high          valid & ready
//  blk_out   out   out_word_low, out_word_high                valid & ready
//  cfg       in    index (0 rounds, 1..4 key words), data     valid & ready
//
//  one block enters per cycle unless the skid register is full; each block passes
//  through the half-round pipeline, one registered half-round per stage
//  stages beyond the configured round count pass the block through unchanged
//  a two-entry output (last stage plus skid register) lets input keep flowing
//  while one result waits; the whole pipeline stalls only while the skid is full
//  reset clears valid bits and loads round_count 32 (capped at MAX_ROUNDS) and an all-zero key
//
module xtea_block_cipher #(
	parameter int unsigned MAX_ROUNDS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	xtea_in_if.sink    blk_in,
	xtea_out_if.source blk_out,
	xtea_cfg_if.sink   cfg
);
	import xtea_pkg::*;

	localparam int unsigned NS   = 2 * MAX_ROUNDS;
	localparam int unsigned NW   = $clog2(MAX_ROUNDS + 1);
	localparam int unsigned RST_N = (ROUND_COUNT_RST < MAX_ROUNDS) ? ROUND_COUNT_RST : MAX_ROUNDS;
	localparam logic [63:0] RST_SUM = 64'(DELTA) * 64'(RST_N);

	// configuration: effective (saturated) round count and decrypt start sum
	logic [NW-1:0] n_q;
	logic [31:0]   dec_sum_q;
	key_t          key_q;

	logic [ROUND_COUNT_W-1:0] rc_wr;
	logic [NW-1:0]            n_wr;
	logic [31:0]              sum_wr;

	assign cfg.ready = 1'b1;
	assign rc_wr  = cfg.data[ROUND_COUNT_W-1:0];
	assign n_wr   = (32'(rc_wr) > 32'(MAX_ROUNDS)) ? NW'(MAX_ROUNDS) : NW'(rc_wr);
	assign sum_wr = DELTA * 32'(n_wr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q       <= NW'(RST_N);
			dec_sum_q <= RST_SUM[31:0];
			key_q     <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_ROUND_COUNT: begin
					n_q       <= n_wr;
					dec_sum_q <= sum_wr;
				end
				REG_KEY_WORD_0: key_q[0] <= cfg.data;
				REG_KEY_WORD_1: key_q[1] <= cfg.data;
				REG_KEY_WORD_2: key_q[2] <= cfg.data;
				REG_KEY_WORD_3: key_q[3] <= cfg.data;
				default: ; // writes beyond the register list are dropped
			endcase
		end
	end

	// pipeline advance: held only while the skid register is occupied
	logic   skid_valid_q;
	stage_t skid_q;
	logic   en;

	assign en           = !skid_valid_q;
	assign blk_in.ready = en;

	// pipeline entry: the running sum starts at zero or at delta * n
	stage_t pipe  [NS+1];
	logic   valid [NS+1];

	always_comb begin
		pipe[0].op  = blk_in.opcode;
		pipe[0].v0  = blk_in.in_word_low;
		pipe[0].v1  = blk_in.in_word_high;
		pipe[0].sum = (blk_in.opcode == OP_DECRYPT) ? dec_sum_q : '0;
	end
	assign valid[0] = blk_in.valid;

	for (genvar j = 0; j < NS; j++) begin : g_stage
		logic active;
		// stage pair j/2 holds one full round, run only below the round count
		assign active = (32'(j / 2) < 32'(n_q));

		xtea_half_round #(
			.SECOND_HALF ((j % 2) == 1)
		) u_half (
			.clk          (clk),
			.arst_n       (arst_n),
			.en           (en),
			.active       (active),
			.key          (key_q),
			.in_valid     (valid[j]),
			.in_stage     (pipe[j]),
			.out_valid_s1 (valid[j+1]),
			.out_stage_s1 (pipe[j+1])
		);
	end

	// skid register: catches the last stage's block when the sink stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (blk_out.ready) skid_valid_q <= 1'b0;
		end else if (valid[NS] && !blk_out.ready) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_valid_q && valid[NS] && !blk_out.ready) begin
			skid_q <= pipe[NS];
		end
	end

	// skid holds the older block, so it goes out first
	assign blk_out.valid         = skid_valid_q || valid[NS];
	assign blk_out.out_word_low  = skid_valid_q ? skid_q.v0 : pipe[NS].v0;
	assign blk_out.out_word_high = skid_valid_q ? skid_q.v1 : pipe[NS].v1;

endmodule

@@ rtl/xtea_checker.sv @@
// ----------------------------------------------------------------------------
// xtea_checker
// port-level checks on the xtea block cipher, bound to the top level
// ----------------------------------------------------------------------------
module xtea_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_word_low,
	input logic [31:0] out_word_high,
	input logic        cfg_ready
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_word_low) && $stable(out_word_high))
		else $error("result changed while stalled");

	// input is refused only after the sink held off a waiting result
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> $past(out_valid && !out_ready))
		else $error("input refused without an output stall");

	// once reset has been seen at an edge, nothing comes out and config is taken
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n && $past(!arst_n) |-> !out_valid && cfg_ready)
		else $error("output or config port active during reset");

endmodule

bind xtea_block_cipher xtea_checker u_xtea_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (blk_in.ready),
	.out_valid     (blk_out.valid),
	.out_ready     (blk_out.ready),
	.out_word_low  (blk_out.out_word_low),
	.out_word_high (blk_out.out_word_high),
	.cfg_ready     (cfg.ready)
);
